// ===== rtl/ssm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, sizes and font table of the scrolling segment marquee.
// ----------------------------------------------------------------------------
package ssm_pkg;

   // sizes of the display and of the text store
   localparam int DIGITS      = 5;
   localparam int MAX_CHARS   = 32;
   localparam int MESSAGES    = 3;

   localparam int MEM_DEPTH   = MESSAGES * MAX_CHARS;
   localparam int ADDR_W      = $clog2(MEM_DEPTH);
   localparam int LEN_W       = $clog2(MAX_CHARS + 1);
   localparam int CPOS_W      = $clog2(MAX_CHARS + 2 * DIGITS);

   // field widths fixed by the interface
   localparam int MSG_W       = 2;
   localparam int POS_W       = 5;
   localparam int CHAR_W      = 8;
   localparam int SEG_W       = 14;
   localparam int EN_W        = 5;
   localparam int DIG_W       = 3;
   localparam int PERIOD_W    = 16;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd50;

   localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_Z = 8'h5A;

   // item kinds
   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_LOAD = 1'b1
   } kind_type;

   // input item
   typedef struct packed {
      kind_type           kind;
      logic               button_level;
      logic [MSG_W-1:0]   load_message;
      logic [POS_W-1:0]   load_position;
      logic [CHAR_W-1:0]  load_char;
   } req_type;

   // result item
   typedef struct packed {
      logic [SEG_W-1:0]   segments;
      logic [EN_W-1:0]    digit_enable;
      logic [DIG_W-1:0]   digit_index;
      logic [MSG_W-1:0]   message_now;
   } rsp_type;

   // 14-segment font for capital letters, blank for anything else
   function automatic logic [SEG_W-1:0] glyph_of(input logic [CHAR_W-1:0] ch);
      logic [SEG_W-1:0] seg;
      seg = '0;
      if (ch >= CHAR_A && ch <= CHAR_Z) begin
         case (5'(ch - CHAR_A))
            5'd0:    seg = 14'd8759;
            5'd1:    seg = 14'd2703;
            5'd2:    seg = 14'd57;
            5'd3:    seg = 14'd2191;
            5'd4:    seg = 14'd8761;
            5'd5:    seg = 14'd8753;
            5'd6:    seg = 14'd573;
            5'd7:    seg = 14'd8758;
            5'd8:    seg = 14'd2185;
            5'd9:    seg = 14'd30;
            5'd10:   seg = 14'd9520;
            5'd11:   seg = 14'd56;
            5'd12:   seg = 14'd374;
            5'd13:   seg = 14'd1142;
            5'd14:   seg = 14'd63;
            5'd15:   seg = 14'd8755;
            5'd16:   seg = 14'd4159;
            5'd17:   seg = 14'd9779;
            5'd18:   seg = 14'd8749;
            5'd19:   seg = 14'd2177;
            5'd20:   seg = 14'd62;
            5'd21:   seg = 14'd4400;
            5'd22:   seg = 14'd5174;
            5'd23:   seg = 14'd5440;
            5'd24:   seg = 14'd2368;
            5'd25:   seg = 14'd4361;
            default: seg = '0;
         endcase
      end
      return seg;
   endfunction

endpackage

// ===== rtl/scrolling_segment_marquee.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrolling_segment_marquee
// Scrolling text marquee for a row of multiplexed 14-segment digits. Text
// lives in a synchronous memory; scroll and scan control sit in registers.
// ----------------------------------------------------------------------------
//  channel   prefix  direction  payload              transfer when
//  input     req_    in         ssm_pkg::req_type    req_valid & !req_stall
//  result    rsp_    out        ssm_pkg::rsp_type    rsp_valid & !rsp_stall
//  register  csr_    in         scroll period        csr_write_enable
//
//  one item per cycle while req_ is not stalled; a scan tick gives its result
//  through the text memory read, then the output register; a load gives none
//  the text memory read stage and the output register lie between the two sides
//  reset needs no clearing pass: text beyond a message's length is never shown
//  a stall on rsp_ holds the result and stalls req_ once the read stage is full
// ----------------------------------------------------------------------------
module scrolling_segment_marquee (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ssm_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ssm_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_enable,
   input  logic [ssm_pkg::PERIOD_W-1:0]       csr_write_data
);
   import ssm_pkg::*;

   // read stage control
   typedef struct packed {
      logic               hit;
      logic [DIG_W-1:0]   digit;
      logic [MSG_W-1:0]   sel;
   } rd_ctl_type;

   logic [PERIOD_W-1:0]  period_ff;
   logic [MSG_W-1:0]     sel_ff,      sel_in;
   logic [CPOS_W-1:0]    scroll_ff,   scroll_in;
   logic [PERIOD_W-1:0]  pre_ff,      pre_in;
   logic [DIG_W-1:0]     digit_ff,    digit_in;
   logic                 button_ff;
   logic [LEN_W-1:0]     len_ff [MESSAGES];

   logic [CHAR_W-1:0]    text_mem [MEM_DEPTH];
   logic [CHAR_W-1:0]    rd_char_ff;
   rd_ctl_type           rd_ctl_ff,   rd_ctl_in;
   logic                 rd_valid_ff;

   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   logic                 advance;
   logic                 accept;
   logic                 tick_accept;
   logic                 load_accept;
   logic                 load_ok;
   logic                 press;
   logic [MSG_W-1:0]     sel_edge;
   logic [CPOS_W-1:0]    scroll_edge;
   logic [PERIOD_W-1:0]  pre_edge;
   logic [LEN_W-1:0]     len_sel;
   logic [CPOS_W:0]      scroll_step;
   logic [CPOS_W:0]      cpos;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic [LEN_W-1:0]     load_len;

   // handshake
   assign advance     = !(rsp_valid_ff && rsp_stall);
   assign req_stall   = rd_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign tick_accept = accept && (req_data.kind == KIND_TICK);
   assign load_accept = accept && (req_data.kind == KIND_LOAD);

   // load checks and store address
   assign load_ok  = (32'(req_data.load_message) < MESSAGES)
                  && (32'(req_data.load_position) < MAX_CHARS);
   assign wr_addr  = ADDR_W'(int'(req_data.load_message) * MAX_CHARS
                  + int'(req_data.load_position));
   assign load_len = LEN_W'(req_data.load_position) + LEN_W'(1);

   // button edge, prescaler and scroll step for a scan tick
   always_comb begin
      press       = button_ff && !req_data.button_level;
      sel_edge    = sel_ff;
      scroll_edge = scroll_ff;
      pre_edge    = pre_ff;
      if (press) begin
         sel_edge    = (32'(sel_ff) >= MESSAGES - 1) ? '0 : sel_ff + MSG_W'(1);
         scroll_edge = '0;
         pre_edge    = '0;
      end
      sel_in  = sel_edge;
      len_sel = len_ff[sel_edge];
      scroll_step = (CPOS_W + 1)'(scroll_edge) + (CPOS_W + 1)'(1);
      if (pre_edge < period_ff) begin
         pre_in    = pre_edge + PERIOD_W'(1);
         scroll_in = scroll_edge;
      end else begin
         pre_in = '0;
         if (scroll_step > (CPOS_W + 1)'(len_sel) + (CPOS_W + 1)'(DIGITS)) begin
            scroll_in = '0;
         end else begin
            scroll_in = CPOS_W'(scroll_step);
         end
      end
      digit_in = (32'(digit_ff) >= DIGITS - 1) ? '0 : digit_ff + DIG_W'(1);
      cpos     = (CPOS_W + 1)'(scroll_in) + (CPOS_W + 1)'(digit_ff);
      rd_ctl_in.hit   = cpos < (CPOS_W + 1)'(len_sel);
      rd_ctl_in.digit = digit_ff;
      rd_ctl_in.sel   = sel_edge;
      rd_addr = ADDR_W'(int'(sel_edge) * MAX_CHARS + int'(cpos[CPOS_W-1:0]));
   end

   // scroll period register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_write_enable) begin
         period_ff <= csr_write_data;
      end
   end

   // scan and scroll state
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff    <= '0;
         scroll_ff <= '0;
         pre_ff    <= '0;
         digit_ff  <= '0;
         button_ff <= 1'b1;
      end else if (tick_accept) begin
         sel_ff    <= sel_in;
         scroll_ff <= scroll_in;
         pre_ff    <= pre_in;
         digit_ff  <= digit_in;
         button_ff <= req_data.button_level;
      end
   end

   // message lengths grow with the highest position loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < MESSAGES; m++) begin
            len_ff[m] <= '0;
         end
      end else if (load_accept && load_ok) begin
         for (int m = 0; m < MESSAGES; m++) begin
            if (32'(req_data.load_message) == m && load_len > len_ff[m]) begin
               len_ff[m] <= load_len;
            end
         end
      end
   end

   // text memory: write on load, registered read on tick
   always_ff @(posedge clock) begin
      if (load_accept && load_ok) begin
         text_mem[wr_addr] <= req_data.load_char;
      end
      if (tick_accept) begin
         rd_char_ff <= text_mem[rd_addr];
         rd_ctl_ff  <= rd_ctl_in;
      end
   end

   // read stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         rd_valid_ff <= tick_accept;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && rd_valid_ff) begin
         rsp_ff.segments     <= rd_ctl_ff.hit ? glyph_of(rd_char_ff) : '0;
         rsp_ff.digit_enable <= EN_W'(1) << rd_ctl_ff.digit;
         rsp_ff.digit_index  <= rd_ctl_ff.digit;
         rsp_ff.message_now  <= rd_ctl_ff.sel;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/ssm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks of the scrolling segment marquee, bound to the top level.
// ----------------------------------------------------------------------------
module ssm_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  ssm_pkg::req_type                   req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  ssm_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_enable,
   input  logic [ssm_pkg::PERIOD_W-1:0]       csr_write_data
);
   import ssm_pkg::*;

   // a stalled request holds until its transfer
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // exactly one digit enabled, matching the index, index and message in range
   a_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_data.digit_enable)
         && rsp_data.digit_enable == (EN_W'(1) << rsp_data.digit_index)
         && 32'(rsp_data.digit_index) < DIGITS
         && 32'(rsp_data.message_now) < MESSAGES)
      else $error("digit enable, digit index or message out of line");

   // period written only with nothing in flight
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |-> !req_valid && !rsp_valid && !$isunknown(csr_write_data))
      else $error("period written while busy");

   // nothing shows straight after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind scrolling_segment_marquee ssm_checker u_ssm_checker (.*);

// ===== dv/scrolling_segment_marquee_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrolling_segment_marquee_tb
// Self-checking bench for the scrolling marquee. A queue of load and scan
// items feeds a clocked driver. Every transfer accepted on req_ updates a
// behavioural copy of the marquee, which queues the frame it expects. A
// clocked monitor checks each rsp_ transfer against the oldest expected
// frame. The run moves through several scroll periods and idle/stall mixes.
// ----------------------------------------------------------------------------
module scrolling_segment_marquee_tb;
   import ssm_pkg::*;

   localparam int CLK_HALF   = 10;
   localparam int SETTLE_CYC = 6;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   logic             req_stall;
   req_type          req_data         = '0;
   logic             rsp_valid;
   logic             rsp_stall        = 1'b0;
   rsp_type          rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [PERIOD_W-1:0] csr_write_data = '0;

   // stimulus and expected frames
   req_type          queued_items[$];
   rsp_type          expected_frames[$];
   int               mismatch_count   = 0;
   int               send_idle_pct    = 0;
   int               recv_stall_pct   = 0;

   // lengths as the stimulus has built them, kept free of unwritten gaps
   int               gen_len[MESSAGES] = '{default: 0};

   // behavioural copy of the marquee state
   logic [CHAR_W-1:0]   text_mem[MESSAGES][MAX_CHARS];
   int                  msg_len[MESSAGES] = '{default: 0};
   int                  cur_msg           = 0;
   int                  scroll_pos        = 0;
   int                  prescale          = 0;
   int                  digit_now         = 0;
   bit                  btn_prev          = 1'b1;
   logic [PERIOD_W-1:0] scroll_period     = PERIOD_RESET;

   // letter font, 'A' first
   logic [SEG_W-1:0] letter_font[26] = '{
      14'd8759, 14'd2703, 14'd57,   14'd2191, 14'd8761, 14'd8753, 14'd573,
      14'd8758, 14'd2185, 14'd30,   14'd9520, 14'd56,   14'd374,  14'd1142,
      14'd63,   14'd8755, 14'd4159, 14'd9779, 14'd8749, 14'd2177, 14'd62,
      14'd4400, 14'd5174, 14'd5440, 14'd2368, 14'd4361
   };

   scrolling_segment_marquee u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // clock
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // advance the marquee copy by one item, true when it yields a frame
   function automatic bit predict_marquee(input req_type it, output rsp_type frame);
      int len;
      int cpos;
      frame = '0;
      if (it.kind == KIND_LOAD) begin
         // every 5-bit position is in range, only the store number can be bad
         if (int'(it.load_message) < MESSAGES) begin
            text_mem[it.load_message][it.load_position] = it.load_char;
            if (int'(it.load_position) + 1 > msg_len[it.load_message])
               msg_len[it.load_message] = int'(it.load_position) + 1;
         end
         return 1'b0;
      end
      // falling button edge selects the next message and restarts the scroll
      if (btn_prev && !it.button_level) begin
         cur_msg    = (cur_msg == MESSAGES - 1) ? 0 : cur_msg + 1;
         scroll_pos = 0;
         prescale   = 0;
      end
      btn_prev = it.button_level;
      len = msg_len[cur_msg];
      // scroll prescaler
      if (prescale < scroll_period) begin
         prescale++;
      end else begin
         prescale = 0;
         scroll_pos++;
         if (scroll_pos > len + DIGITS)
            scroll_pos = 0;
      end
      // character under the active digit, blank past the end or for non-letters
      cpos = scroll_pos + digit_now;
      if (cpos < len && text_mem[cur_msg][cpos] >= CHAR_A
          && text_mem[cur_msg][cpos] <= CHAR_Z)
         frame.segments = letter_font[text_mem[cur_msg][cpos] - CHAR_A];
      frame.digit_enable = EN_W'(1 << digit_now);
      frame.digit_index  = DIG_W'(digit_now);
      frame.message_now  = MSG_W'(cur_msg);
      digit_now = (digit_now == DIGITS - 1) ? 0 : digit_now + 1;
      return 1'b1;
   endfunction

   function automatic void push_tick(input bit level);
      req_type it;
      it.kind          = KIND_TICK;
      it.button_level  = level;
      it.load_message  = MSG_W'($urandom_range(3));
      it.load_position = POS_W'($urandom_range(31));
      it.load_char     = CHAR_W'($urandom_range(255));
      queued_items.push_back(it);
   endfunction

   function automatic void push_load(input int msg, input int pos, input logic [7:0] ch);
      req_type it;
      it.kind          = KIND_LOAD;
      it.button_level  = 1'($urandom_range(1));
      it.load_message  = MSG_W'(msg);
      it.load_position = POS_W'(pos);
      it.load_char     = ch;
      queued_items.push_back(it);
      if (msg < MESSAGES && pos + 1 > gen_len[msg])
         gen_len[msg] = pos + 1;
   endfunction

   function automatic logic [7:0] rand_char();
      return ($urandom_range(99) < 70) ? CHAR_W'($urandom_range(65, 90))
                                       : CHAR_W'($urandom_range(255));
   endfunction

   // random mix of scan runs, message loads, rewrites and bad loads
   task automatic gen_random(input int count);
      int done;
      int pick;
      int n;
      int press;
      int msg;
      int span;
      bit down;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            // scan run, sometimes opened by a button press
            n     = $urandom_range(1, 30);
            press = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
            for (int i = 0; i < n; i++)
               push_tick(i >= press);
            done += n;
         end else if (pick < 80) begin
            // whole message, now and then written top down
            msg  = $urandom_range(MESSAGES - 1);
            n    = $urandom_range(99);
            span = (n < 70) ? $urandom_range(1, 6) :
                   (n < 95) ? $urandom_range(7, 16) : $urandom_range(17, MAX_CHARS);
            down = ($urandom_range(4) == 0);
            for (int i = 0; i < span; i++)
               push_load(msg, down ? span - 1 - i : i, rand_char());
            done += span;
         end else if (pick < 93) begin
            // rewrite inside a message already written
            msg = $urandom_range(MESSAGES - 1);
            if (gen_len[msg] > 0) begin
               push_load(msg, $urandom_range(gen_len[msg] - 1), rand_char());
               done++;
            end
         end else begin
            // load to a store that does not exist
            push_load(MESSAGES + $urandom_range(3 - MESSAGES), $urandom_range(31),
                      CHAR_W'($urandom_range(255)));
         end
      end
   endtask

   // wait until every item has gone and every frame has come back
   task automatic wait_idle();
      do
         @(negedge clock);
      while (queued_items.size() != 0 || req_valid || expected_frames.size() != 0);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // new scroll period and idle mix, written with the block idle
   task automatic set_phase(input logic [PERIOD_W-1:0] period, input int s_idle,
                            input int r_stall);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= period;
      scroll_period     = period;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      send_idle_pct     = s_idle;
      recv_stall_pct    = r_stall;
      @(negedge clock);
   endtask

   // driver: present queued items, update the marquee copy on each transfer
   always @(posedge clock) begin : item_driver
      rsp_type frame;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (predict_marquee(req_data, frame))
               expected_frames.push_back(frame);
         end
         if (!req_valid || !req_stall) begin
            if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= queued_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each frame transfer with the oldest expected frame
   always @(posedge clock) begin : frame_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected frame seg %h en %b dig %0d msg %0d", $time,
                           rsp_data.segments, rsp_data.digit_enable,
                           rsp_data.digit_index, rsp_data.message_now);
            end else begin
               want = expected_frames.pop_front();
               if (rsp_data.segments !== want.segments
                   || rsp_data.digit_enable !== want.digit_enable
                   || rsp_data.digit_index !== want.digit_index
                   || rsp_data.message_now !== want.message_now) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: frame mismatch, expected seg %h en %b dig %0d msg %0d,",
                               " got seg %h en %b dig %0d msg %0d"}, $time,
                              want.segments, want.digit_enable, want.digit_index,
                              want.message_now, rsp_data.segments, rsp_data.digit_enable,
                              rsp_data.digit_index, rsp_data.message_now);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // test sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, scroll on every tick
      set_phase(PERIOD_W'(0), 0, 0);
      // blank display before any text is loaded
      push_tick(1'b1);
      push_tick(1'b1);
      // message 0: first and last letter, codes either side of the letters, code extremes
      push_load(0, 0, "A");
      push_load(0, 1, "Z");
      push_load(0, 2, 8'h40);
      push_load(0, 3, 8'h5B);
      push_load(0, 4, 8'hFF);
      push_load(0, 5, 8'h00);
      // load to a store that does not exist
      push_load(3, 31, "Q");
      // message 1 written top down, gap closed before the next tick
      push_load(1, 2, "M");
      push_load(1, 1, "K");
      push_load(1, 0, "B");
      // scroll across message 0
      for (int i = 0; i < 5; i++)
         push_tick(1'b1);
      // presses step through the messages, a held press does nothing, then wrap
      push_tick(1'b0);
      push_tick(1'b1);
      push_tick(1'b0);
      push_tick(1'b0);
      push_tick(1'b1);
      push_tick(1'b0);
      push_tick(1'b1);

      // random phases over several periods and idle mixes
      set_phase(PERIOD_W'(2), 0, 0);
      gen_random(400);
      set_phase(PERIOD_W'(16'hFFFF), 46, 0);
      gen_random(300);
      set_phase(PERIOD_W'(1), 0, 46);
      gen_random(400);
      set_phase(PERIOD_W'(0), 29, 29);
      gen_random(400);
      set_phase(PERIOD_W'(5), 46, 0);
      gen_random(250);
      set_phase(PERIOD_RESET, 29, 29);
      gen_random(250);

      wait_idle();
      if (mismatch_count == 0 && expected_frames.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ssm_pkg.sv
rtl/scrolling_segment_marquee.sv
rtl/ssm_checker.sv
dv/scrolling_segment_marquee_tb.sv
